[rtl/partition_count_parts_at_most_k_macros.svh]
// Assertion macros used by the checker file
`ifndef PARTITION_COUNT_PARTS_AT_MOST_K_MACROS_SVH
`define PARTITION_COUNT_PARTS_AT_MOST_K_MACROS_SVH

// Property checked at every clock edge outside reset
`define PCPK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pcpk check failed");

// Property checked at every clock edge, reset included
`define PCPK_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("pcpk check failed");

`endif

[rtl/pcpk_pkg.sv]
package pcpk_pkg;

   // Field widths
   localparam int TARGET_W   = 14;
   localparam int PART_W     = 4;
   localparam int REQ_DATA_W = 24;
   localparam int COUNT_W    = 64;

   // Default sizing
   localparam int MAX_TARGET_DEF = 8192;
   localparam int MAX_PART_DEF   = 10;

   // Column marker that travels down the cell row with each count
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } col_type;

endpackage

[rtl/pcpk_cell.sv]
// One part size of the recurrence: y[i] = x[i] + y[i-PART], saturating; an inactive cell passes x through.
module pcpk_cell #(
   parameter int PART = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          active,
   input  pcpk_pkg::col_type             x_col,
   input  logic [pcpk_pkg::COUNT_W-1:0]  x_data,
   output pcpk_pkg::col_type             y_col,
   output logic [pcpk_pkg::COUNT_W-1:0]  y_data,
   output logic                          y_carry
);
   import pcpk_pkg::*;

   logic [COUNT_W-1:0] dl_ff [PART];
   logic [COUNT_W-1:0] data_ff;
   logic [COUNT_W-1:0] data_in;
   col_type            col_ff;
   logic               carry_ff;
   logic               carry_in;
   logic [COUNT_W-1:0] term;
   logic [COUNT_W:0]   sum;

   // Saturating add of the own output PART columns back
   always_comb begin
      term = x_col.first ? '0 : dl_ff[PART-1];
      sum  = {1'b0, x_data} + {1'b0, term};
      if (active) begin
         data_in  = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
         carry_in = x_col.vld & sum[COUNT_W];
      end else begin
         data_in  = x_data;
         carry_in = 1'b0;
      end
   end

   // Control stage
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         carry_ff <= 1'b0;
      end else begin
         col_ff   <= x_col;
         carry_ff <= carry_in;
      end
   end

   // Output and delay line; the first column wipes older history
   always_ff @(posedge clock) begin
      if (x_col.vld) begin
         data_ff  <= data_in;
         dl_ff[0] <= data_in;
         for (int j = 1; j < PART; j++) begin
            dl_ff[j] <= x_col.first ? '0 : dl_ff[j-1];
         end
      end
   end

   assign y_col   = col_ff;
   assign y_data  = data_ff;
   assign y_carry = carry_ff;

endmodule

[rtl/partition_count_parts_at_most_k.sv]
// Channel | Dir | Fields (lowest bit up)                           | Transfer
// req     | in  | tdata: target_value[13:0], largest_part[17:14]   | tvalid & tready
// rsp     | out | tdata: partition_count[63:0]; tuser: overflowed  | tvalid & tready
//
// For a query with clamped target n, columns 0..n enter the row of MAX_PART
// cells one per cycle, then drain through the row.
// A new query is taken while the previous result still waits on rsp.
// Synchronous active-high reset returns the control to idle with rsp empty.
module partition_count_parts_at_most_k #(
   parameter int MAX_TARGET = pcpk_pkg::MAX_TARGET_DEF,
   parameter int MAX_PART   = pcpk_pkg::MAX_PART_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // target_value[13:0], largest_part[17:14], zero [23:18]
   input  logic [pcpk_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // partition_count[63:0]
   output logic [pcpk_pkg::COUNT_W-1:0]     rsp_tdata,
   // overflowed[0]
   output logic [0:0]                       rsp_tuser
);
   import pcpk_pkg::*;

   localparam int ColW  = $clog2(MAX_TARGET + 1);
   localparam int PartW = $clog2(MAX_PART + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FEED  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_WAIT  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [ColW-1:0]    col_ff, col_in;
   logic [ColW-1:0]    tgt_ff, tgt_in;
   logic [PartW-1:0]   k_ff, k_in;
   logic               sat_ff;
   logic [COUNT_W-1:0] pend_cnt_ff;
   logic               pend_ovf_ff;
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_cnt_ff;
   logic               rsp_ovf_ff;

   logic [TARGET_W-1:0] req_target;
   logic [PART_W-1:0]   req_part;
   logic                req_xfer, rsp_xfer, end_done, ovf_now, rsp_load;

   col_type            chain_col  [MAX_PART+1];
   logic [COUNT_W-1:0] chain_data [MAX_PART+1];
   logic [MAX_PART-1:0] cell_carry;
   logic [MAX_PART-1:0] part_act;

   // Request unpacking and clamping
   assign req_target = req_tdata[TARGET_W-1:0];
   assign req_part   = req_tdata[TARGET_W+PART_W-1:TARGET_W];
   assign tgt_in = (32'(req_target) > MAX_TARGET) ? ColW'(MAX_TARGET) : ColW'(req_target);
   assign k_in   = (32'(req_part) > MAX_PART) ? PartW'(MAX_PART) : PartW'(req_part);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign rsp_xfer   = rsp_valid_ff & rsp_tready;
   assign end_done   = chain_col[MAX_PART].vld & chain_col[MAX_PART].last;
   assign ovf_now    = sat_ff | (|cell_carry);
   assign rsp_load   = (state_ff == ST_WAIT) & (~rsp_valid_ff | rsp_tready);

   // Column source for the first cell: 1 at column 0, else 0
   always_comb begin
      chain_col[0].vld   = (state_ff == ST_FEED);
      chain_col[0].first = (col_ff == '0);
      chain_col[0].last  = (col_ff == tgt_ff);
      chain_data[0]      = COUNT_W'(col_ff == '0);
   end

   // Cell row, one cell per part size
   for (genvar g = 0; g < MAX_PART; g++) begin : g_cell
      assign part_act[g] = (k_ff >= PartW'(g + 1));
      pcpk_cell #(
         .PART (g + 1)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .active  (part_act[g]),
         .x_col   (chain_col[g]),
         .x_data  (chain_data[g]),
         .y_col   (chain_col[g+1]),
         .y_data  (chain_data[g+1]),
         .y_carry (cell_carry[g])
      );
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      case (state_ff)
         ST_IDLE: begin
            col_in = '0;
            if (req_xfer) begin
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            col_in = col_ff + ColW'(1);
            if (col_ff == tgt_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (end_done) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         sat_ff   <= req_xfer ? 1'b0 : ovf_now;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Query operands and results
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         tgt_ff <= tgt_in;
         k_ff   <= k_in;
      end
      if (state_ff == ST_DRAIN && end_done) begin
         pend_cnt_ff <= (k_ff == '0) ? '0 : chain_data[MAX_PART];
         pend_ovf_ff <= (k_ff != '0) & ovf_now;
      end
      if (rsp_load) begin
         rsp_cnt_ff <= pend_cnt_ff;
         rsp_ovf_ff <= pend_ovf_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_cnt_ff;
   assign rsp_tuser[0] = rsp_ovf_ff;

endmodule

[rtl/pcpk_checker.sv]
`include "partition_count_parts_at_most_k_macros.svh"

module pcpk_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [pcpk_pkg::COUNT_W-1:0]  rsp_tdata,
   input logic [0:0]                    rsp_tuser
);
   import pcpk_pkg::*;

   // A stalled result holds
   `PCPK_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // One query at a time: not ready right after a request transfer
   `PCPK_ASSERT(a_one_query, clock, reset, req_tvalid && req_tready |=> !req_tready)

   // An overflowed count shows saturated
   `PCPK_ASSERT(a_sat_value, clock, reset, rsp_tvalid && rsp_tuser[0] |-> (&rsp_tdata))

   // Reset leaves the block idle and empty
   `PCPK_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> req_tready && !rsp_tvalid)

endmodule

bind partition_count_parts_at_most_k pcpk_checker u_pcpk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
